// ===== rtl/rsc_pkg.sv =====
// Shared types, codes and defaults for the register shadow cache.
package rsc_pkg;

    // Default sizes handed to the top level parameters.
    localparam int ADDR_SPACE_DEF   = 256;
    localparam int TIME_WIDTH_DEF   = 32;
    localparam int EXEMPT_SLOTS_DEF = 4;

    // Number of exempt address registers in the register map.
    localparam int EXEMPT_REGS = 4;

    // Field widths.
    localparam int ADDR_W   = 8;
    localparam int VALUE_W  = 16;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int EXPIRY_W = 32;
    localparam int COUNT_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Command codes carried in the input tuser.
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    // Result status codes carried in the output tuser.
    localparam logic [STATUS_W-1:0] RS_OK             = 2'd0;
    localparam logic [STATUS_W-1:0] RS_OUT_OF_WINDOW  = 2'd1;
    localparam logic [STATUS_W-1:0] RS_NO_DATA        = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LOW      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_HIGH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXEMPT_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXEMPT_0     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EXEMPT_1     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_EXEMPT_2     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_EXEMPT_3     = 3'd7;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INDEX,
        ST_ACCESS,
        ST_LIMIT,
        ST_FINISH
    } rsc_state_t;

    // Configuration register contents.
    typedef struct packed {
        logic [ADDR_W-1:0]                   win_low;
        logic [ADDR_W-1:0]                   win_high;
        logic [EXPIRY_W-1:0]                 expiry;
        logic [COUNT_W-1:0]                  exempt_count;
        logic [EXEMPT_REGS-1:0][ADDR_W-1:0]  exempt_addr;
    } rsc_cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic calc_index;
        logic access;
        logic calc_limit;
        logic load_out;
    } rsc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mem_op;
        logic is_read;
        logic out_free;
    } rsc_stat_t;

endpackage

// ===== rtl/rsc_ctrl.sv =====
// Controller state machine sequencing one command through the datapath.
module rsc_ctrl
    import rsc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  rsc_stat_t  stat,
    output rsc_cmd_t   cmd
);

    rsc_state_t state_reg;
    rsc_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_INDEX;
                end
            end
            ST_INDEX: begin
                state_next = stat.mem_op ? ST_ACCESS : ST_FINISH;
            end
            ST_ACCESS: begin
                state_next = stat.is_read ? ST_LIMIT : ST_FINISH;
            end
            ST_LIMIT: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_INDEX: begin
                cmd.calc_index = 1'b1;
            end
            ST_ACCESS: begin
                cmd.access = 1'b1;
            end
            ST_LIMIT: begin
                cmd.calc_limit = 1'b1;
            end
            ST_FINISH: begin
                cmd.load_out = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // A result is only loaded into a free output register.
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> stat.out_free)
        else $error("result loaded while output register busy");

    // An accepted beat always moves on to index calculation.
    a_accept_index: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> state_reg == ST_INDEX)
        else $error("accepted beat did not enter index stage");

    // The expiry limit is only formed right after a memory access.
    a_limit_after_access: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LIMIT |-> $past(state_reg) == ST_ACCESS)
        else $error("limit stage entered without a memory access");

endmodule

// ===== rtl/rsc_dpath.sv =====
// Datapath: index calculation, value and stamp stores, expiry check, output register.
module rsc_dpath
    import rsc_pkg::*;
#(
    parameter int ADDR_SPACE   = ADDR_SPACE_DEF,
    parameter int TIME_WIDTH   = TIME_WIDTH_DEF,
    parameter int EXEMPT_SLOTS = EXEMPT_SLOTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rsc_cmd_t             cmd,
    output rsc_stat_t            stat,
    input  rsc_cfg_t             cfg,
    input  logic [23:0]          s_tdata,
    input  logic [CMD_W-1:0]     s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,
    output logic [STATUS_W-1:0]  m_tuser
);

    localparam int IDX_W = $clog2(ADDR_SPACE);
    // Reciprocal for the entry index modulo; exact for 8-bit offsets.
    localparam int unsigned RECIP = (65536 + ADDR_SPACE - 1) / ADDR_SPACE;
    localparam logic [24:0] RECIP_V = RECIP[24:0];
    localparam logic [15:0] SPACE_V = ADDR_SPACE[15:0];

    // Captured command.
    logic [CMD_W-1:0]   op_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [VALUE_W-1:0] wval_reg;
    logic               win_reg;
    logic [ADDR_W-1:0]  diff_reg;

    // Index stage.
    logic [IDX_W-1:0]   idx_reg;
    logic               exempt_reg;
    logic [24:0]        prod;
    logic [ADDR_W-1:0]  quot;
    logic [15:0]        qmul;
    logic [ADDR_W-1:0]  rem;
    logic               exempt_hit;

    // Stores and read data.
    logic [VALUE_W-1:0]    value_mem [ADDR_SPACE];
    logic [TIME_WIDTH-1:0] stamp_mem [ADDR_SPACE];
    logic [ADDR_SPACE-1:0] valid_reg;
    logic [VALUE_W-1:0]    value_rd_reg;
    logic [TIME_WIDTH-1:0] stamp_rd_reg;
    logic                  vld_rd_reg;

    // Time and expiry.
    logic [TIME_WIDTH-1:0] time_now_reg;
    logic [TIME_WIDTH-1:0] limit_reg;
    logic [TIME_WIDTH-1:0] expiry_t;
    logic [63:0]           expiry_wide;
    logic [TIME_WIDTH-1:0] age_diff;
    logic                  fresh;

    // Result and output register.
    logic [VALUE_W-1:0]  res_value;
    logic [STATUS_W-1:0] res_status;
    logic                m_tvalid_reg;
    logic [VALUE_W-1:0]  m_tdata_reg;
    logic [STATUS_W-1:0] m_tuser_reg;

    // Capture the accepted beat with its window test and window offset.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg   <= s_tuser;
            addr_reg <= s_tdata[7:0];
            wval_reg <= s_tdata[23:8];
            win_reg  <= (s_tdata[7:0] >= cfg.win_low) && (s_tdata[7:0] <= cfg.win_high);
            diff_reg <= s_tdata[7:0] - cfg.win_low;
        end
    end

    // Time counter advances on every accepted tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_now_reg <= '0;
        end else if (cmd.accept && s_tuser == CMD_TICK) begin
            time_now_reg <= time_now_reg + 1'b1;
        end
    end

    // Offset modulo the address space by reciprocal multiplication.
    always_comb begin
        prod = {17'd0, diff_reg} * RECIP_V;
        quot = prod[23:16];
        qmul = {8'd0, quot} * SPACE_V;
        rem  = diff_reg - qmul[7:0];
    end

    // Exempt list match over the slots in use.
    always_comb begin
        exempt_hit = 1'b0;
        for (int i = 0; i < EXEMPT_REGS; i++) begin
            if (i < int'(cfg.exempt_count) && i < EXEMPT_SLOTS &&
                cfg.exempt_addr[i] == addr_reg) begin
                exempt_hit = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc_index) begin
            idx_reg    <= rem[IDX_W-1:0];
            exempt_reg <= exempt_hit;
        end
    end

    // Value and stamp stores: one write or one registered read per access.
    always_ff @(posedge aclk) begin
        if (cmd.access) begin
            if (op_reg == CMD_WRITE) begin
                value_mem[idx_reg] <= wval_reg;
                stamp_mem[idx_reg] <= time_now_reg;
            end else begin
                value_rd_reg <= value_mem[idx_reg];
                stamp_rd_reg <= stamp_mem[idx_reg];
            end
        end
    end

    // Valid bits, cleared together at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.access && op_reg == CMD_WRITE) begin
            valid_reg[idx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.access) begin
            vld_rd_reg <= valid_reg[idx_reg];
        end
    end

    // Expiry limit is the stamp plus the expiry time, wrapping.
    always_comb begin
        expiry_wide = {32'd0, cfg.expiry};
        expiry_t    = expiry_wide[TIME_WIDTH-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc_limit) begin
            limit_reg <= stamp_rd_reg + expiry_t;
        end
    end

    // Entry is fresh while the signed difference now minus limit is negative.
    always_comb begin
        age_diff = time_now_reg - limit_reg;
        fresh    = age_diff[TIME_WIDTH-1];
    end

    // Result selection.
    always_comb begin
        res_value  = '0;
        res_status = RS_OK;
        if (op_reg == CMD_READ || op_reg == CMD_WRITE) begin
            if (!win_reg) begin
                res_status = RS_OUT_OF_WINDOW;
            end else if (op_reg == CMD_READ) begin
                if (vld_rd_reg && (exempt_reg || fresh)) begin
                    res_value = value_rd_reg;
                end else begin
                    res_status = RS_NO_DATA;
                end
            end
        end
    end

    // Output register holds the result beat until it is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tdata_reg <= res_value;
            m_tuser_reg <= res_status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign stat.mem_op   = win_reg && (op_reg == CMD_READ || op_reg == CMD_WRITE);
    assign stat.is_read  = (op_reg == CMD_READ);
    assign stat.out_free = !m_tvalid_reg || m_tready;

    // A write access leaves its entry marked valid.
    a_write_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.access && op_reg == CMD_WRITE) |=> valid_reg[$past(idx_reg)])
        else $error("written entry not marked valid");

    // Any status other than ok carries a zero value.
    a_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg != RS_OK) |-> m_tdata_reg == '0)
        else $error("non-zero value with failing status");

    // A tick moves the time counter on by exactly one.
    a_tick_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && s_tuser == CMD_TICK) |=>
            time_now_reg == $past(time_now_reg) + 1'b1)
        else $error("tick did not advance time by one");

endmodule

// ===== rtl/register_shadow_cache_with_expiry_core.sv =====
// Top level of the register shadow cache: configuration registers, controller and datapath.
//
//  Channel | Ports                          | Beat contents
//  --------+--------------------------------+-----------------------------------------
//  input   | s_tvalid s_tready s_tdata s_tuser | command, register address, write value
//  result  | m_tvalid m_tready m_tdata m_tuser | read value, status
//  config  | cfg_valid cfg_ready cfg_index cfg_data | register index, write data
//
// A tick, an unused command or an access outside the window runs through the index and
// finish states to the result beat; a write adds the access state, a read the access and
// limit states for the registered value and stamp read and the stamp-plus-expiry addition.
// The next input beat is accepted once the previous result sits in the output register.
// Reset clears all valid bits together; there is no clearing pass after reset.
// A stalled result beat holds the block in its final step until the output register frees.
module register_shadow_cache_with_expiry_core
    import rsc_pkg::*;
#(
    parameter int ADDR_SPACE   = ADDR_SPACE_DEF,
    parameter int TIME_WIDTH   = TIME_WIDTH_DEF,
    parameter int EXEMPT_SLOTS = EXEMPT_SLOTS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Input channel.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [23:0]            s_tdata,   // [7:0] reg_addr, [23:8] write_value
    input  logic [CMD_W-1:0]       s_tuser,   // [1:0] command
    // Result channel.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [15:0]            m_tdata,   // [15:0] read_value
    output logic [STATUS_W-1:0]    m_tuser,   // [1:0] status
    // Configuration write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    rsc_cfg_t  cfg_reg;
    rsc_cmd_t  cmd;
    rsc_stat_t stat;

    assign cfg_ready = 1'b1;

    // Configuration registers, written one beat at a time.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.win_low      <= '0;
            cfg_reg.win_high     <= 8'd255;
            cfg_reg.expiry       <= '0;
            cfg_reg.exempt_count <= '0;
            cfg_reg.exempt_addr  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_WIN_LOW:      cfg_reg.win_low        <= cfg_data[7:0];
                CFG_WIN_HIGH:     cfg_reg.win_high       <= cfg_data[7:0];
                CFG_EXPIRY:       cfg_reg.expiry         <= cfg_data;
                CFG_EXEMPT_COUNT: cfg_reg.exempt_count   <= cfg_data[2:0];
                CFG_EXEMPT_0:     cfg_reg.exempt_addr[0] <= cfg_data[7:0];
                CFG_EXEMPT_1:     cfg_reg.exempt_addr[1] <= cfg_data[7:0];
                CFG_EXEMPT_2:     cfg_reg.exempt_addr[2] <= cfg_data[7:0];
                CFG_EXEMPT_3:     cfg_reg.exempt_addr[3] <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Controller.
    rsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath.
    rsc_dpath #(
        .ADDR_SPACE   (ADDR_SPACE),
        .TIME_WIDTH   (TIME_WIDTH),
        .EXEMPT_SLOTS (EXEMPT_SLOTS)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .cfg      (cfg_reg),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
